[rtl/affine_matrix_compose_4x4_macros.svh]
// ----------------------------------------------------------------------------
// affine_matrix_compose_4x4 assertion macros
// Shorthand for the concurrent checks on the composer's ports.
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_COMPOSE_4X4_MACROS_SVH
`define AFFINE_MATRIX_COMPOSE_4X4_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AMC4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define AMC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication, disabled during reset.
`define AMC4_ASSERT_AFTER4(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##4 (cons)) \
		else $error(msg);

`endif

[rtl/amc4_pkg.sv]
// ----------------------------------------------------------------------------
// amc4_pkg
// Word formats, mode codes and controller-to-datapath command type.
// ----------------------------------------------------------------------------
package amc4_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	// four products summed: two guard bits
	localparam int ACC_BITS  = PROD_BITS + 2;

	localparam logic [1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [1:0] MODE_COMPUTE = 2'd2;

	localparam logic signed [WORD_BITS-1:0] FIX_ONE  = WORD_BITS'(1) << FRAC_BITS;
	localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic       load_a;
		logic       load_b;
		logic       step;
		logic       first;
		logic       last_k;
		logic [1:0] i;
		logic [1:0] j;
		logic [1:0] k;
	} amc4_cmd_t;

	typedef struct packed {
		logic last_done;
	} amc4_status_t;

endpackage

[rtl/amc4_ctrl.sv]
// ----------------------------------------------------------------------------
// amc4_ctrl
// Sequencer: decodes words, steps the 64 multiply-accumulates of a compute.
// ----------------------------------------------------------------------------
module amc4_ctrl
	import amc4_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   mode,
	input  logic [1:0]   row_index,
	input  amc4_status_t status,
	output amc4_cmd_t    cmd,
	output logic         busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       busy_q;
	logic       accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_comb begin
		cmd        = '0;
		cmd.load_a = accept && (mode == MODE_LOAD_A);
		// B bottom row is fixed; drop writes to it
		cmd.load_b = accept && (mode == MODE_LOAD_B) && (row_index != 2'd3);
		cmd.step   = (state_q == ST_RUN);
		cmd.i      = cnt_q[5:4];
		cmd.j      = cnt_q[3:2];
		cmd.k      = cnt_q[1:0];
		cmd.first  = (cnt_q[1:0] == 2'd0);
		cmd.last_k = (cnt_q[1:0] == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_COMPUTE)) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						busy_q  <= 1'b1;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold until the final entry leaves the datapath
					if (status.last_done) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

[rtl/amc4_datapath.sv]
// ----------------------------------------------------------------------------
// amc4_datapath
// Matrix stores, shared multiply-accumulate pipe, truncation/saturation and
// row write-back of the product into A.
// ----------------------------------------------------------------------------
module amc4_datapath
	import amc4_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  amc4_cmd_t                   cmd,
	input  logic [1:0]                  row_index,
	input  logic [1:0]                  col_index,
	input  logic signed [WORD_BITS-1:0] element_value,
	output amc4_status_t                status,
	output logic                        strobe,
	output logic [1:0]                  out_row,
	output logic [1:0]                  out_col,
	output logic signed [WORD_BITS-1:0] product_value,
	output logic                        saturated,
	output logic                        last
);

	typedef struct packed {
		logic       first;
		logic       last_k;
		logic [1:0] i;
		logic [1:0] j;
	} tag_t;

	logic signed [WORD_BITS-1:0] left_q  [16];
	logic signed [WORD_BITS-1:0] right_q [12];
	logic signed [WORD_BITS-1:0] prow_q  [3];

	logic                        vld_s1, vld_s2, fin_s3;
	tag_t                        tag_s1, tag_s2, tag_s3;
	logic signed [WORD_BITS-1:0] a_s1, b_s1;
	logic signed [PROD_BITS-1:0] p_s2;
	logic signed [ACC_BITS-1:0]  acc_q;

	logic                        strobe_q, last_q, sat_q;
	logic [1:0]                  row_q, col_q;
	logic signed [WORD_BITS-1:0] val_q;

	logic [ACC_BITS-FRAC_BITS-WORD_BITS:0] hi_bits;
	logic                        sat_now;
	logic signed [WORD_BITS-1:0] val_now;

	// sum >>> FRAC_BITS fits the word when the bits above the word are all sign
	always_comb begin
		hi_bits = acc_q[ACC_BITS-1:FRAC_BITS+WORD_BITS-1];
		sat_now = !((&hi_bits) || !(|hi_bits));
		if (sat_now) begin
			val_now = acc_q[ACC_BITS-1] ? WORD_MIN : WORD_MAX;
		end else begin
			val_now = acc_q[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
		end
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			fin_s3   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1   <= cmd.step;
			vld_s2   <= vld_s1;
			fin_s3   <= vld_s2 && tag_s2.last_k;
			strobe_q <= fin_s3;
		end
	end

	// operand fetch, multiply, accumulate
	always_ff @(posedge clk) begin
		tag_s1 <= '{first: cmd.first, last_k: cmd.last_k, i: cmd.i, j: cmd.j};
		a_s1   <= left_q[{cmd.i, cmd.k}];
		if (cmd.k == 2'd3) begin
			b_s1 <= (cmd.j == 2'd3) ? FIX_ONE : '0;
		end else begin
			b_s1 <= right_q[{cmd.k, cmd.j}];
		end
		tag_s2 <= tag_s1;
		p_s2   <= a_s1 * b_s1;
		if (vld_s2) begin
			tag_s3 <= tag_s2;
			if (tag_s2.first) begin
				acc_q <= ACC_BITS'(p_s2);
			end else begin
				acc_q <= acc_q + ACC_BITS'(p_s2);
			end
		end
	end

	// result register, matrix stores and row write-back
	always_ff @(posedge clk) begin
		if (fin_s3) begin
			row_q  <= tag_s3.i;
			col_q  <= tag_s3.j;
			val_q  <= val_now;
			sat_q  <= sat_now;
			last_q <= (tag_s3.i == 2'd3) && (tag_s3.j == 2'd3);
			if (tag_s3.j != 2'd3) begin
				prow_q[tag_s3.j] <= val_now;
			end else begin
				// row finished and no longer read: overwrite A row
				left_q[{tag_s3.i, 2'd0}] <= prow_q[0];
				left_q[{tag_s3.i, 2'd1}] <= prow_q[1];
				left_q[{tag_s3.i, 2'd2}] <= prow_q[2];
				left_q[{tag_s3.i, 2'd3}] <= val_now;
			end
		end else if (cmd.load_a) begin
			left_q[{row_index, col_index}] <= element_value;
		end
		if (cmd.load_b) begin
			right_q[{row_index, col_index}] <= element_value;
		end
	end

	assign strobe           = strobe_q;
	assign out_row          = row_q;
	assign out_col          = col_q;
	assign product_value    = val_q;
	assign saturated        = sat_q;
	assign last             = last_q;
	assign status.last_done = strobe_q && last_q;

endmodule

[rtl/affine_matrix_compose_4x4.sv]
// ----------------------------------------------------------------------------
// affine_matrix_compose_4x4
// Composes 4x4 affine transforms in signed Q16.16: P = A * B, P written back
// into A. Bottom row of B is fixed at 0,0,0,1.
//
//  channel   handshake                 payload
//  input     start / busy              mode, row_index, col_index, element_value
//  result    strobe (one cycle)        out_row, out_col, product_value,
//                                      saturated, last
//
// A load word leaves busy low, so loads stream at one per cycle while no
// compute is running. A compute word raises busy; one shared multiply-
// accumulate does four products per entry, so each entry leaves once its
// four products are summed. Busy falls the cycle after last.
// The receiver cannot stall; results are shown for exactly one cycle.
// Reset clears control only; matrix contents are undefined until loaded.
// ----------------------------------------------------------------------------
module affine_matrix_compose_4x4
	import amc4_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  mode,
	input  logic [1:0]                  row_index,
	input  logic [1:0]                  col_index,
	input  logic signed [WORD_BITS-1:0] element_value,
	output logic                        strobe,
	output logic [1:0]                  out_row,
	output logic [1:0]                  out_col,
	output logic signed [WORD_BITS-1:0] product_value,
	output logic                        saturated,
	output logic                        last
);

	amc4_cmd_t    cmd;
	amc4_status_t status;

	amc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.row_index (row_index),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	amc4_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.status        (status),
		.strobe        (strobe),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_value (product_value),
		.saturated     (saturated),
		.last          (last)
	);

endmodule

[rtl/amc4_checker.sv]
// ----------------------------------------------------------------------------
// amc4_checker
// Port-level checks on busy, strobe spacing and the end of a compute.
// ----------------------------------------------------------------------------
`include "affine_matrix_compose_4x4_macros.svh"

module amc4_checker
	import amc4_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       strobe,
	input logic       last
);

	`AMC4_ASSERT_NOW(a_strobe_in_busy, clk, arst_n, strobe, busy, "result outside a compute")
	`AMC4_ASSERT_NEXT(a_compute_busy, clk, arst_n, start && !busy && (mode == MODE_COMPUTE), busy, "compute word did not raise busy")
	`AMC4_ASSERT_NEXT(a_load_no_busy, clk, arst_n, start && !busy && (mode != MODE_COMPUTE), !busy, "load word raised busy")
	`AMC4_ASSERT_NEXT(a_last_ends, clk, arst_n, strobe && last, !busy, "busy held after last entry")
	`AMC4_ASSERT_AFTER4(a_entry_spacing, clk, arst_n, strobe && !last, strobe, "entries not four cycles apart")

endmodule

bind affine_matrix_compose_4x4 amc4_checker u_amc4_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.mode   (mode),
	.strobe (strobe),
	.last   (last)
);
